@@ src/particle_contact_resolver_assert.svh @@
// Assertion macros shared by the contact resolver RTL.
// Included by files that check their own pipeline behaviour.
`ifndef PARTICLE_CONTACT_RESOLVER_ASSERT_SVH
`define PARTICLE_CONTACT_RESOLVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("contact resolver check failed");

// Next-cycle implication, disabled during reset.
`define PCR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("contact resolver check failed");

`endif

@@ src/pcr_pkg.sv @@
// Widths, pipeline depths and helper functions for the contact resolver.
// No dependencies; used by the interfaces and every module.
package pcr_pkg;

  localparam int unsigned CW        = 21;
  localparam int unsigned VW        = 3 * CW;
  localparam int unsigned DW        = CW + 1;
  localparam int unsigned IMW       = 24;
  localparam int unsigned ISW       = IMW + 1;
  localparam int unsigned PENW      = 20;
  localparam int unsigned EW        = 16;
  localparam int unsigned E1W       = EW + 1;
  localparam int unsigned FRAC_W    = 10;
  localparam int unsigned E_FRAC    = 15;
  localparam int unsigned NRM_SHIFT = 19;
  localparam int unsigned SQ_PREC   = 18;

  localparam logic [E1W-1:0] E_ONE = E1W'(1) << E_FRAC;

  localparam int unsigned SQRT_IN_W   = 64;
  localparam int unsigned ROOT_W      = 32;
  localparam int unsigned SQRT_STAGES = ROOT_W;
  localparam int unsigned SQRT_LAT    = SQRT_STAGES + 1;

  localparam int unsigned DIV_NUM_W = 61;
  localparam int unsigned DIV_DEN_W = 32;
  localparam int unsigned DIV_Q_W   = 36;
  localparam int unsigned DIV_OUT_W = DIV_Q_W + 1;
  localparam int unsigned DIV_LAT   = DIV_Q_W + 1;

  function automatic logic signed [CW-1:0] comp_of(input logic [VW-1:0] v, input int i);
    return $signed(v[i*CW +: CW]);
  endfunction

  function automatic logic signed [CW-1:0] sat_c(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (CW - 1)) - 64'sd1;
    lo = -(64'sd1 <<< (CW - 1));
    if (x > hi) return hi[CW-1:0];
    else if (x < lo) return lo[CW-1:0];
    return x[CW-1:0];
  endfunction

  // Divide by 2^s, rounding half away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                   input int unsigned s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? 64'(-x) : 64'(x);
    r   = (mag + (64'd1 << (s - 1))) >> s;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

@@ src/pcr_if.sv @@
// Valid/ready channel interfaces for contacts in and resolved results out.
// Depends on pcr_pkg for the field widths.
interface pcr_contact_if;
  logic                          valid;
  logic                          ready;
  logic [pcr_pkg::VW-1:0]        first_position;
  logic [pcr_pkg::VW-1:0]        second_position;
  logic [pcr_pkg::VW-1:0]        first_velocity;
  logic [pcr_pkg::VW-1:0]        second_velocity;
  logic [pcr_pkg::VW-1:0]        contact_normal;
  logic [pcr_pkg::IMW-1:0]       first_inverse_mass;
  logic [pcr_pkg::IMW-1:0]       second_inverse_mass;
  logic [pcr_pkg::PENW-1:0]      penetration;
  logic [pcr_pkg::EW-1:0]        restitution;
  logic                          two_body;

  modport source (output valid, first_position, second_position, first_velocity,
                  second_velocity, contact_normal, first_inverse_mass,
                  second_inverse_mass, penetration, restitution, two_body,
                  input ready);
  modport sink (input valid, first_position, second_position, first_velocity,
                second_velocity, contact_normal, first_inverse_mass,
                second_inverse_mass, penetration, restitution, two_body,
                output ready);
endinterface

interface pcr_result_if;
  logic                   valid;
  logic                   ready;
  logic [pcr_pkg::VW-1:0] new_first_position;
  logic [pcr_pkg::VW-1:0] new_second_position;
  logic [pcr_pkg::VW-1:0] new_first_velocity;
  logic [pcr_pkg::VW-1:0] new_second_velocity;
  logic                   degenerate;

  modport source (output valid, new_first_position, new_second_position,
                  new_first_velocity, new_second_velocity, degenerate,
                  input ready);
  modport sink (input valid, new_first_position, new_second_position,
                new_first_velocity, new_second_velocity, degenerate,
                output ready);
endinterface

@@ src/pcr_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on pcr_pkg for widths and depth.
module pcr_sqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [pcr_pkg::SQRT_IN_W-1:0]    x,
  output logic [pcr_pkg::ROOT_W-1:0]       root
);

  localparam int unsigned XW = pcr_pkg::SQRT_IN_W;
  localparam int unsigned NS = pcr_pkg::SQRT_STAGES;

  logic [XW-1:0] xq [NS+1];
  logic [XW-1:0] rq [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      xq[0] <= x;
      rq[0] <= '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int unsigned SH = 2 * (NS - 1 - k);
    logic [XW-1:0] trial;
    assign trial = rq[k] + (XW'(1) << SH);

    always_ff @(posedge clk) begin
      if (en) begin
        if (xq[k] >= trial) begin
          xq[k+1] <= xq[k] - trial;
          rq[k+1] <= (rq[k] >> 1) + (XW'(1) << SH);
        end else begin
          xq[k+1] <= xq[k];
          rq[k+1] <= rq[k] >> 1;
        end
      end
    end
  end

  assign root = rq[NS][pcr_pkg::ROOT_W-1:0];

endmodule

@@ src/pcr_div.sv @@
// Pipelined signed divider, one quotient bit per stage, rounding half away
// from zero. Depends on pcr_pkg for widths and depth.
module pcr_div (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [pcr_pkg::DIV_NUM_W-1:0]   num,
  input  logic        [pcr_pkg::DIV_DEN_W-1:0]   den,
  output logic signed [pcr_pkg::DIV_OUT_W-1:0]   quo
);

  localparam int unsigned MW = pcr_pkg::DIV_NUM_W;
  localparam int unsigned NW = MW + 1;
  localparam int unsigned QW = pcr_pkg::DIV_Q_W;
  localparam int unsigned RW = pcr_pkg::DIV_DEN_W;

  logic [MW-1:0] mag;
  logic [NW-1:0] biased;

  logic [RW-1:0] rm [QW+1];
  logic [QW-1:0] lo [QW+1];
  logic [QW-1:0] qt [QW+1];
  logic [RW-1:0] dn [QW+1];
  logic          ng [QW+1];

  assign mag    = num[MW-1] ? MW'(-num) : MW'(num);
  // Add half the divisor so the truncating division rounds
  assign biased = {1'b0, mag} + NW'(den >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rm[0] <= RW'(biased[NW-1:QW]);
      lo[0] <= biased[QW-1:0];
      qt[0] <= '0;
      dn[0] <= den;
      ng[0] <= num[MW-1];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW:0] t;
    logic [RW:0] diff;
    logic        ge;
    assign t    = {rm[k], lo[k][QW-1]};
    assign diff = t - {1'b0, dn[k]};
    assign ge   = t >= {1'b0, dn[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k+1] <= ge ? diff[RW-1:0] : t[RW-1:0];
        lo[k+1] <= lo[k] << 1;
        qt[k+1] <= {qt[k][QW-2:0], ge};
        dn[k+1] <= dn[k];
        ng[k+1] <= ng[k];
      end
    end
  end

  assign quo = ng[QW] ? -$signed({1'b0, qt[QW]}) : $signed({1'b0, qt[QW]});

endmodule

@@ src/particle_contact_resolver.sv @@
// Impulse contact resolver: one contact per cycle in, one result per contact out.
// Depth comes from the square-root pipeline for the pair normal (33 stages) and
// two long-division pipelines (37 stages each) for the normal and the
// inverse-mass shares. The whole pipeline holds while a finished result waits on
// the output; nothing is dropped or repeated.
// Depends on pcr_pkg, pcr_if, pcr_sqrt and pcr_div.
`include "particle_contact_resolver_assert.svh"

module particle_contact_resolver (
  input logic          clk,
  input logic          rst,
  pcr_contact_if.sink  contact,
  pcr_result_if.source result
);

  localparam int unsigned CW        = pcr_pkg::CW;
  localparam int unsigned VW        = pcr_pkg::VW;
  localparam int unsigned DW        = pcr_pkg::DW;
  localparam int unsigned IMW       = pcr_pkg::IMW;
  localparam int unsigned ISW       = pcr_pkg::ISW;
  localparam int unsigned PENW      = pcr_pkg::PENW;
  localparam int unsigned E1W       = pcr_pkg::E1W;
  localparam int unsigned FRAC_W    = pcr_pkg::FRAC_W;
  localparam int unsigned SQRT_LAT  = pcr_pkg::SQRT_LAT;
  localparam int unsigned DIV_LAT   = pcr_pkg::DIV_LAT;
  localparam int unsigned NUM_W     = pcr_pkg::DIV_NUM_W;
  localparam int unsigned DEN_W     = pcr_pkg::DIV_DEN_W;
  localparam int unsigned QO_W      = pcr_pkg::DIV_OUT_W;
  localparam int unsigned SQR_W     = 2 * DW - 1;
  localparam int unsigned SQ_W      = SQR_W + 1;
  localparam int unsigned PV_W      = DW + CW;
  localparam int unsigned PP_W      = CW + PENW + 1;
  localparam int unsigned DSUM_W    = PV_W + 2;
  localparam int unsigned DOT_W     = DSUM_W - FRAC_W;
  localparam int unsigned Q_W       = PP_W - FRAC_W;
  localparam int unsigned M_W       = DOT_W + ISW;
  localparam int unsigned QM_W      = Q_W + ISW;
  localparam int unsigned O_W       = Q_W;
  localparam int unsigned SP_W      = QO_W + E1W + 1;
  localparam int unsigned S_W       = SP_W - pcr_pkg::E_FRAC;
  localparam int unsigned CH_W      = CW + S_W;

  typedef struct packed {
    logic                  valid;
    logic                  pair;
    logic                  degen;
    logic [VW-1:0]         p1w;
    logic [VW-1:0]         p2w;
    logic [VW-1:0]         v1w;
    logic [VW-1:0]         v2w;
    logic [VW-1:0]         nw;
    logic [IMW-1:0]        im1;
    logic [IMW-1:0]        im2;
    logic [ISW-1:0]        imsum;
    logic [PENW-1:0]       pen;
    logic [E1W-1:0]        e1;
    logic [2:0][DW-1:0]    d;
    logic [2:0][DW-1:0]    vrel;
    logic [2:0][CW-1:0]    n;
  } ctx_t;

  logic en;
  assign en            = !result.valid || result.ready;
  assign contact.ready = en;

  // Stage A: capture, separation and relative velocity
  ctx_t a, a_next;

  always_comb begin
    a_next       = '0;
    a_next.valid = contact.valid;
    a_next.pair  = contact.two_body;
    a_next.p1w   = contact.first_position;
    a_next.p2w   = contact.second_position;
    a_next.v1w   = contact.first_velocity;
    a_next.v2w   = contact.second_velocity;
    a_next.nw    = contact.contact_normal;
    a_next.im1   = contact.first_inverse_mass;
    a_next.im2   = contact.two_body ? contact.second_inverse_mass : '0;
    a_next.imsum = ISW'(contact.first_inverse_mass) + ISW'(a_next.im2);
    a_next.pen   = contact.penetration;
    a_next.e1    = E1W'(contact.restitution) + pcr_pkg::E_ONE;
    for (int i = 0; i < 3; i++) begin
      a_next.d[i] = DW'(pcr_pkg::comp_of(contact.first_position, i))
                  - DW'(pcr_pkg::comp_of(contact.second_position, i));
      a_next.vrel[i] = DW'(pcr_pkg::comp_of(contact.first_velocity, i))
                     - (contact.two_body ? DW'(pcr_pkg::comp_of(contact.second_velocity, i))
                                         : DW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) a.valid <= 1'b0;
    else if (en) a <= a_next;
  end

  // Stage B: squared separation components
  ctx_t b;
  logic signed [2*DW-1:0] sqp [3];
  logic [SQR_W-1:0]       sqr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) sqp[i] = $signed(a.d[i]) * $signed(a.d[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b.valid <= 1'b0;
    end else if (en) begin
      b <= a;
      for (int i = 0; i < 3; i++) sqr[i] <= sqp[i][SQR_W-1:0];
    end
  end

  // Stage C: squared distance, degenerate check, root operand
  ctx_t c, c_next;
  logic [SQ_W-1:0]                 sq_sum;
  logic [pcr_pkg::SQRT_IN_W-1:0]   root_in;

  always_comb begin
    sq_sum       = SQ_W'(sqr[0]) + SQ_W'(sqr[1]) + SQ_W'(sqr[2]);
    c_next       = b;
    c_next.degen = (b.imsum == '0) || (b.pair && sq_sum == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c.valid <= 1'b0;
    end else if (en) begin
      c       <= c_next;
      root_in <= pcr_pkg::SQRT_IN_W'({sq_sum, {pcr_pkg::SQ_PREC{1'b0}}});
    end
  end

  logic [pcr_pkg::ROOT_W-1:0] root;

  pcr_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (root_in),
    .root (root)
  );

  ctx_t cs [SQRT_LAT];
  ctx_t cs_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQRT_LAT; i++) cs[i].valid <= 1'b0;
    end else if (en) begin
      cs[0] <= c;
      for (int i = 1; i < SQRT_LAT; i++) cs[i] <= cs[i-1];
    end
  end

  assign cs_o = cs[SQRT_LAT-1];

  // Pair normal: d * 2^19 / root per component
  logic signed [QO_W-1:0] nq [3];

  for (genvar g = 0; g < 3; g++) begin : g_ndiv
    logic signed [NUM_W-1:0] nnum;
    assign nnum = NUM_W'($signed({cs_o.d[g], {pcr_pkg::NRM_SHIFT{1'b0}}}));

    pcr_div u_div (
      .clk (clk),
      .en  (en),
      .num (nnum),
      .den (DEN_W'(root)),
      .quo (nq[g])
    );
  end

  ctx_t dv [DIV_LAT];
  ctx_t dv_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) dv[i].valid <= 1'b0;
    end else if (en) begin
      dv[0] <= cs_o;
      for (int i = 1; i < DIV_LAT; i++) dv[i] <= dv[i-1];
    end
  end

  assign dv_o = dv[DIV_LAT-1];

  // Stage N: pick the normal
  ctx_t ns, ns_next;

  always_comb begin
    ns_next = dv_o;
    for (int i = 0; i < 3; i++) begin
      ns_next.n[i] = dv_o.pair ? pcr_pkg::sat_c(64'(nq[i]))
                               : pcr_pkg::comp_of(dv_o.nw, i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ns.valid <= 1'b0;
    else if (en) ns <= ns_next;
  end

  // Stage D1: per-component products
  ctx_t d1;
  logic signed [PV_W-1:0] pv_c [3];
  logic signed [PP_W-1:0] pp_c [3];
  logic signed [PV_W-1:0] pv_r [3];
  logic signed [PP_W-1:0] pp_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pv_c[i] = $signed(ns.vrel[i]) * $signed(ns.n[i]);
      pp_c[i] = $signed(ns.n[i]) * $signed({1'b0, ns.pen});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1.valid <= 1'b0;
    end else if (en) begin
      d1 <= ns;
      for (int i = 0; i < 3; i++) begin
        pv_r[i] <= pv_c[i];
        pp_r[i] <= pp_c[i];
      end
    end
  end

  // Stage D2: closing speed and scaled penetration
  ctx_t d2;
  logic signed [DSUM_W-1:0] dsum;
  logic signed [63:0]       dot_w;
  logic signed [63:0]       q_w [3];
  logic signed [DOT_W-1:0]  dot_r;
  logic signed [Q_W-1:0]    q_r [3];

  always_comb begin
    dsum  = DSUM_W'(pv_r[0]) + DSUM_W'(pv_r[1]) + DSUM_W'(pv_r[2]);
    dot_w = pcr_pkg::rnd_shift(64'(dsum), FRAC_W);
    for (int i = 0; i < 3; i++) q_w[i] = pcr_pkg::rnd_shift(64'(pp_r[i]), FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d2.valid <= 1'b0;
    end else if (en) begin
      d2    <= d1;
      dot_r <= dot_w[DOT_W-1:0];
      for (int i = 0; i < 3; i++) q_r[i] <= q_w[i][Q_W-1:0];
    end
  end

  // Stage D3: weight by each body's inverse mass
  ctx_t d3;
  logic signed [M_W-1:0]  m1, m2;
  logic signed [QM_W-1:0] qm1 [3];
  logic signed [QM_W-1:0] qm2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      d3.valid <= 1'b0;
    end else if (en) begin
      d3 <= d2;
      m1 <= dot_r * $signed({1'b0, d2.im1});
      m2 <= dot_r * $signed({1'b0, d2.im2});
      for (int i = 0; i < 3; i++) begin
        qm1[i] <= q_r[i] * $signed({1'b0, d2.im1});
        qm2[i] <= q_r[i] * $signed({1'b0, d2.im2});
      end
    end
  end

  // Shares of the total inverse mass
  logic signed [QO_W-1:0] w1q, w2q;
  logic signed [QO_W-1:0] o1q [3];
  logic signed [QO_W-1:0] o2q [3];

  pcr_div u_div_w1 (
    .clk (clk), .en (en), .num (NUM_W'(m1)), .den (DEN_W'(d3.imsum)), .quo (w1q)
  );

  pcr_div u_div_w2 (
    .clk (clk), .en (en), .num (NUM_W'(m2)), .den (DEN_W'(d3.imsum)), .quo (w2q)
  );

  for (genvar g = 0; g < 3; g++) begin : g_pdiv
    pcr_div u_div_o1 (
      .clk (clk), .en (en), .num (NUM_W'(qm1[g])), .den (DEN_W'(d3.imsum)), .quo (o1q[g])
    );
    pcr_div u_div_o2 (
      .clk (clk), .en (en), .num (NUM_W'(qm2[g])), .den (DEN_W'(d3.imsum)), .quo (o2q[g])
    );
  end

  ctx_t wl [DIV_LAT];
  ctx_t wl_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) wl[i].valid <= 1'b0;
    end else if (en) begin
      wl[0] <= d3;
      for (int i = 1; i < DIV_LAT; i++) wl[i] <= wl[i-1];
    end
  end

  assign wl_o = wl[DIV_LAT-1];

  // Stage E1: apply restitution
  ctx_t e1s;
  logic signed [SP_W-1:0] sp1, sp2;
  logic signed [O_W-1:0]  o1a [3];
  logic signed [O_W-1:0]  o2a [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      e1s.valid <= 1'b0;
    end else if (en) begin
      e1s <= wl_o;
      sp1 <= w1q * $signed({1'b0, wl_o.e1});
      sp2 <= w2q * $signed({1'b0, wl_o.e1});
      for (int i = 0; i < 3; i++) begin
        o1a[i] <= o1q[i][O_W-1:0];
        o2a[i] <= o2q[i][O_W-1:0];
      end
    end
  end

  // Stage E2: impulse magnitudes
  ctx_t e2s;
  logic signed [63:0]    s1_w, s2_w;
  logic signed [S_W-1:0] s1, s2;
  logic signed [O_W-1:0] o1b [3];
  logic signed [O_W-1:0] o2b [3];

  assign s1_w = pcr_pkg::rnd_shift(64'(sp1), pcr_pkg::E_FRAC);
  assign s2_w = pcr_pkg::rnd_shift(64'(sp2), pcr_pkg::E_FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      e2s.valid <= 1'b0;
    end else if (en) begin
      e2s <= e1s;
      s1  <= s1_w[S_W-1:0];
      s2  <= s2_w[S_W-1:0];
      o1b <= o1a;
      o2b <= o2a;
    end
  end

  // Stage E3: impulse along the normal
  ctx_t e3s;
  logic signed [CH_W-1:0] ch1 [3];
  logic signed [CH_W-1:0] ch2 [3];
  logic signed [O_W-1:0]  o1c [3];
  logic signed [O_W-1:0]  o2c [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      e3s.valid <= 1'b0;
    end else if (en) begin
      e3s <= e2s;
      for (int i = 0; i < 3; i++) begin
        ch1[i] <= $signed(e2s.n[i]) * s1;
        ch2[i] <= $signed(e2s.n[i]) * s2;
      end
      o1c <= o1b;
      o2c <= o2b;
    end
  end

  // Stage E4: update, saturate, pack, output register
  ctx_t          o_ctx;
  logic [VW-1:0] np1, np2, nv1, nv2;
  logic [VW-1:0] out_p1, out_p2, out_v1, out_v2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      np1[i*CW +: CW] = pcr_pkg::sat_c(64'(pcr_pkg::comp_of(e3s.p1w, i)) + 64'(o1c[i]));
      np2[i*CW +: CW] = pcr_pkg::sat_c(64'(pcr_pkg::comp_of(e3s.p2w, i)) - 64'(o2c[i]));
      nv1[i*CW +: CW] = pcr_pkg::sat_c(64'(pcr_pkg::comp_of(e3s.v1w, i))
                                     - pcr_pkg::rnd_shift(64'(ch1[i]), FRAC_W));
      nv2[i*CW +: CW] = pcr_pkg::sat_c(64'(pcr_pkg::comp_of(e3s.v2w, i))
                                     + pcr_pkg::rnd_shift(64'(ch2[i]), FRAC_W));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_ctx.valid <= 1'b0;
    end else if (en) begin
      o_ctx  <= e3s;
      // Degenerate contacts pass everything through; a lone body keeps body two
      out_p1 <= e3s.degen ? e3s.p1w : np1;
      out_v1 <= e3s.degen ? e3s.v1w : nv1;
      out_p2 <= (e3s.degen || !e3s.pair) ? e3s.p2w : np2;
      out_v2 <= (e3s.degen || !e3s.pair) ? e3s.v2w : nv2;
    end
  end

  assign result.valid               = o_ctx.valid;
  assign result.new_first_position  = out_p1;
  assign result.new_second_position = out_p2;
  assign result.new_first_velocity  = out_v1;
  assign result.new_second_velocity = out_v2;
  assign result.degenerate          = o_ctx.degen;

  `PCR_ASSERT_NXT(a_accept_enters, clk, rst, contact.valid && contact.ready, a.valid)
  `PCR_ASSERT_NXT(a_stall_holds_root_entry, clk, rst, !en, $stable(c.valid) && $stable(root_in))
  `PCR_ASSERT_IMP(a_degen_passthrough, clk, rst, result.valid && result.degenerate, result.new_first_position == o_ctx.p1w && result.new_first_velocity == o_ctx.v1w)
  `PCR_ASSERT_IMP(a_single_passthrough, clk, rst, result.valid && !o_ctx.pair, result.new_second_position == o_ctx.p2w && result.new_second_velocity == o_ctx.v2w)

endmodule
